// ----- hw/rtl/cpu_process_scheduler_defines.svh -----
// Assertion macros for the CPU process scheduler RTL.
// Used by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef CPU_PROCESS_SCHEDULER_DEFINES_SVH
`define CPU_PROCESS_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define CSCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define CSCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define CSCH_ASSERT_IMP(lbl, ante, cons)
`define CSCH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/csch_pkg.sv -----
// Shared types, constants and helpers of the CPU process scheduler.
// No dependencies.
`timescale 1ns / 1ps
package csch_pkg;

  localparam int NPROC   = 16;
  localparam int SLOT_W  = $clog2(NPROC);
  localparam int LEN_W   = $clog2(NPROC + 1);
  localparam int TIME_W  = 32;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int QUANT_W = 16;
  localparam int MODE_W  = 3;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(1);

  // register indexes of the config port
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  // input transaction kinds
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_FCFS  = 3'd0,
    MODE_SJF   = 3'd1,
    MODE_SRTF  = 3'd2,
    MODE_PRIO  = 3'd3,
    MODE_PPRIO = 3'd4,
    MODE_RR    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_UPD,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_APPEND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remain;
    logic [PRIO_W-1:0]  prio;
  } tentry_t;

  localparam int TENTRY_W = $bits(tentry_t);

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } q_port_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    tentry_t           wdata;
    logic [SLOT_W-1:0] raddr;
  } t_port_t;

  typedef struct packed {
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
    logic [SLOT_W-1:0] finished_id;
    logic              finished;
    logic              dispatched;
    logic [SLOT_W-1:0] running_id;
    logic              idle;
    logic [TIME_W-1:0] time_res;
  } result_t;

  // codes 6 and 7 fall back to fcfs
  function automatic mode_e eff_mode(logic [MODE_W-1:0] m);
    mode_e r;
    r = MODE_FCFS;
    if (m <= MODE_W'(MODE_RR)) r = mode_e'(m);
    return r;
  endfunction

  function automatic logic [BURST_W-1:0] key_of(mode_e m, tentry_t e);
    logic [BURST_W-1:0] k;
    k = '0;
    case (m) inside
      MODE_SJF, MODE_SRTF:   k = e.remain;
      MODE_PRIO, MODE_PPRIO: k = BURST_W'(e.prio);
      default:               k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/cpu_process_scheduler.sv -----
// Top level of the CPU process scheduler: config registers, RAMs, sequencer, result register.
// Depends on csch_pkg, csch_ram and csch_ctrl.
//
// Usage:
//   s_axis carries input transactions. tuser = kind (0 arrival, 1 tick); tdata holds
//   proc_id, burst and priority_req. An arrival gives no result.
//   A tick produces exactly one m_axis transaction with the schedule after that tick.
//   A tick reads and updates the running job, scans the ready queue when needed and,
//   on a dispatch, compacts the queue tail behind the taken entry, then re-appends
//   a preempted job. How long a tick takes is set by the single read port of the
//   ready-queue RAM, which the scan and the compaction both walk one entry per
//   cycle.
//   Only one transaction is in work at a time; s_axis_tready is high when idle.
//   The result sits in an output register, so the next input may be accepted while
//   it waits; a further tick stalls before issue of its own result until the output
//   register has been taken (m_axis_tready).
//   Reset (rst_ni low, async) clears the queue, time, running flag and slot states;
//   mode resets to fcfs, quantum to 1. No memory clearing pass is needed.
//   Config writes (cfg_we_i) must only happen while the block is idle.
`timescale 1ns / 1ps
module cpu_process_scheduler import csch_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [QUANT_W-1:0]   cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // proc_id[3:0] burst[19:4] priority_req[27:20]
  input  logic                 s_axis_tuser,  // kind
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // time_res[31:0] idle[32] running_id[36:33] dispatched[37] finished[38]
  // finished_id[42:39] turnaround[74:43] waiting[106:75], zero pad above
  output logic [111:0]         m_axis_tdata
);

  logic [MODE_W-1:0]  mode_q;
  logic [QUANT_W-1:0] quantum_q;
  logic               out_valid_q;
  result_t            out_q;

  q_port_t            qp;
  t_port_t            tp;
  logic [SLOT_W-1:0]  q_rdata;
  logic [TENTRY_W-1:0] t_rdata_raw;
  tentry_t            t_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  assign t_rdata = t_rdata_raw;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_W'(MODE_FCFS);
      quantum_q <= QUANT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODE) mode_q <= cfg_data_i[MODE_W-1:0];
      if (cfg_idx_i == CFG_QUANTUM) quantum_q <= cfg_data_i;
    end
  end

  // ready queue: slot numbers in the order they were queued
  csch_ram #(.WIDTH(SLOT_W), .DEPTH(NPROC)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qp.we),
    .waddr_i (qp.waddr),
    .wdata_i (qp.wdata),
    .raddr_i (qp.raddr),
    .rdata_o (q_rdata)
  );

  // per-slot table: arrival time, burst, remaining, priority
  csch_ram #(.WIDTH(TENTRY_W), .DEPTH(NPROC)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tp.we),
    .waddr_i (tp.waddr),
    .wdata_i (tp.wdata),
    .raddr_i (tp.raddr),
    .rdata_o (t_rdata_raw)
  );

  csch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_id_i     (s_axis_tdata[3:0]),
    .in_burst_i  (s_axis_tdata[19:4]),
    .in_prio_i   (s_axis_tdata[27:20]),
    .mode_i      (mode_q),
    .quantum_i   (quantum_q),
    .qp_o        (qp),
    .q_rdata_i   (q_rdata),
    .tp_o        (tp),
    .t_rdata_i   (t_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register; refills in the cycle the old transaction leaves
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

endmodule

// ----- hw/rtl/csch_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module csch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/csch_ctrl.sv -----
// Scheduling sequencer: arrival, tick update, queue scan, dispatch, queue compaction and re-append of a preempted job.
// Depends on csch_pkg and cpu_process_scheduler_defines.svh; drives both RAMs.
`timescale 1ns / 1ps
`include "cpu_process_scheduler_defines.svh"
module csch_ctrl import csch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_kind_i,
  input  logic [SLOT_W-1:0]  in_id_i,
  input  logic [BURST_W-1:0] in_burst_i,
  input  logic [PRIO_W-1:0]  in_prio_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [QUANT_W-1:0] quantum_i,
  output q_port_t            qp_o,
  input  logic [SLOT_W-1:0]  q_rdata_i,
  output t_port_t            tp_o,
  input  tentry_t            t_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o
);

  state_e state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [NPROC-1:0]   unfin_q, unfin_d;
  logic               running_q, running_d;
  logic [SLOT_W-1:0]  rslot_q, rslot_d;
  logic [QUANT_W-1:0] ql_q, ql_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic [BURST_W-1:0] run_key_q, run_key_d;
  logic               fin_q, fin_d;
  logic [SLOT_W-1:0]  fin_id_q, fin_id_d;
  logic [TIME_W-1:0]  tat_q, tat_d;
  logic [TIME_W-1:0]  wt_q, wt_d;
  logic               disp_q, disp_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic               s1_v_q, s1_v_d;
  logic [SLOT_W-1:0]  s1_idx_q, s1_idx_d;
  logic               s2_v_q, s2_v_d;
  logic [SLOT_W-1:0]  s2_idx_q, s2_idx_d;
  logic [SLOT_W-1:0]  s2_slot_q, s2_slot_d;
  logic               best_v_q, best_v_d;
  logic [SLOT_W-1:0]  best_idx_q, best_idx_d;
  logic [SLOT_W-1:0]  best_slot_q, best_slot_d;
  logic [BURST_W-1:0] best_key_q, best_key_d;
  logic [LEN_W-1:0]   sh_rd_q, sh_rd_d;
  logic               sh_wv_q, sh_wv_d;
  logic [SLOT_W-1:0]  sh_wa_q, sh_wa_d;
  logic               app_q, app_d;
  logic [SLOT_W-1:0]  app_slot_q, app_slot_d;

  mode_e              eff;
  logic               preemptive;
  logic               in_fire;
  logic               arr_ok;
  logic               upd_fin;
  logic [BURST_W-1:0] new_rem;
  logic [QUANT_W-1:0] ql_dec;
  logic               rr_expire;
  logic               run_after;
  logic [LEN_W-1:0]   len_after;
  logic               need_scan;
  logic               scan_issue;
  logic               scan_done;
  logic               sh_issue;
  logic               sh_done;
  logic               preempt;
  logic               take;
  logic [BURST_W-1:0] scan_key;
  tentry_t            upd_entry;

  assign eff        = eff_mode(mode_i);
  assign preemptive = (eff == MODE_SRTF) || (eff == MODE_PPRIO);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign arr_ok     = in_fire && (in_kind_i == KIND_ARRIVAL) && !unfin_q[in_id_i];

  // tick update of the running job, from its table entry
  assign upd_fin   = (t_rdata_i.remain <= BURST_W'(1));
  assign new_rem   = upd_fin ? '0 : t_rdata_i.remain - BURST_W'(1);
  assign ql_dec    = ql_q - QUANT_W'(1);
  assign rr_expire = (eff == MODE_RR) && !upd_fin && (ql_dec == '0);
  assign run_after = running_q && !upd_fin && !rr_expire;
  assign len_after = len_q + LEN_W'(running_q && rr_expire && (len_q < LEN_W'(NPROC)));
  assign need_scan = (len_after != '0) && (!run_after || preemptive);
  always_comb begin
    upd_entry        = t_rdata_i;
    upd_entry.remain = new_rem;
  end

  assign scan_issue = (state_q == ST_SCAN) && (cnt_q < len_q);
  assign scan_done  = (state_q == ST_SCAN) && !scan_issue && !s1_v_q && !s2_v_q;
  assign scan_key   = key_of(eff, t_rdata_i);
  assign sh_issue   = (state_q == ST_SHIFT) && (sh_rd_q <= len_q);
  assign sh_done    = (state_q == ST_SHIFT) && !sh_issue && !sh_wv_q;
  assign preempt    = running_q && preemptive && best_v_q && (best_key_q < run_key_q);
  assign take       = preempt || (!running_q && best_v_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_fire && in_kind_i == KIND_TICK) state_d = ST_RUN_RD;
      ST_RUN_RD:  state_d = ST_RUN_UPD;
      ST_RUN_UPD: state_d = need_scan ? ST_SCAN : ST_DONE;
      ST_SCAN:    if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE:  state_d = take ? ST_SHIFT : ST_DONE;
      ST_SHIFT:   if (sh_done) state_d = app_q ? ST_APPEND : ST_DONE;
      ST_APPEND:  state_d = ST_DONE;
      ST_DONE:    if (res_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory ports and handshake outputs
  always_comb begin
    qp_o        = '0;
    tp_o        = '0;
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        if (arr_ok) begin
          qp_o.we      = (len_q < LEN_W'(NPROC));
          qp_o.waddr   = len_q[SLOT_W-1:0];
          qp_o.wdata   = in_id_i;
          tp_o.we      = 1'b1;
          tp_o.waddr   = in_id_i;
          tp_o.wdata   = '{arrival: time_q, burst: in_burst_i, remain: in_burst_i,
                           prio: in_prio_i};
        end
      end
      ST_RUN_RD: tp_o.raddr = rslot_q;
      ST_RUN_UPD: begin
        if (running_q) begin
          tp_o.we    = 1'b1;
          tp_o.waddr = rslot_q;
          tp_o.wdata = upd_entry;
          if (rr_expire && (len_q < LEN_W'(NPROC))) begin
            qp_o.we    = 1'b1;
            qp_o.waddr = len_q[SLOT_W-1:0];
            qp_o.wdata = rslot_q;
          end
        end
      end
      ST_SCAN: begin
        qp_o.raddr = cnt_q[SLOT_W-1:0];
        tp_o.raddr = q_rdata_i;
      end
      ST_SHIFT: begin
        qp_o.raddr = sh_rd_q[SLOT_W-1:0];
        if (sh_wv_q) begin
          qp_o.we    = 1'b1;
          qp_o.waddr = sh_wa_q;
          qp_o.wdata = q_rdata_i;
        end
      end
      ST_APPEND: begin
        qp_o.we    = 1'b1;
        qp_o.waddr = len_q[SLOT_W-1:0];
        qp_o.wdata = app_slot_q;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    len_d       = len_q;
    unfin_d     = unfin_q;
    running_d   = running_q;
    rslot_d     = rslot_q;
    ql_d        = ql_q;
    time_d      = time_q;
    run_key_d   = run_key_q;
    fin_d       = fin_q;
    fin_id_d    = fin_id_q;
    tat_d       = tat_q;
    wt_d        = wt_q;
    disp_d      = disp_q;
    cnt_d       = cnt_q;
    s1_v_d      = 1'b0;
    s1_idx_d    = s1_idx_q;
    s2_v_d      = 1'b0;
    s2_idx_d    = s2_idx_q;
    s2_slot_d   = s2_slot_q;
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_slot_d = best_slot_q;
    best_key_d  = best_key_q;
    sh_rd_d     = sh_rd_q;
    sh_wv_d     = 1'b0;
    sh_wa_d     = sh_wa_q;
    app_d       = app_q;
    app_slot_d  = app_slot_q;
    case (state_q)
      ST_IDLE: begin
        if (arr_ok) begin
          unfin_d[in_id_i] = 1'b1;
          if (len_q < LEN_W'(NPROC)) len_d = len_q + LEN_W'(1);
        end
        if (in_fire && in_kind_i == KIND_TICK) begin
          fin_d    = 1'b0;
          fin_id_d = '0;
          tat_d    = '0;
          wt_d     = '0;
          disp_d   = 1'b0;
          app_d    = 1'b0;
        end
      end
      ST_RUN_UPD: begin
        cnt_d    = '0;
        best_v_d = 1'b0;
        if (running_q) begin
          run_key_d = key_of(eff, upd_entry);
          if (upd_fin) begin
            unfin_d[rslot_q] = 1'b0;
            running_d        = 1'b0;
            fin_d            = 1'b1;
            fin_id_d         = rslot_q;
            tat_d            = time_q - t_rdata_i.arrival;
            wt_d             = tat_d - TIME_W'(t_rdata_i.burst);
          end
          if (eff == MODE_RR) begin
            ql_d = ql_dec;
            if (rr_expire) running_d = 1'b0;
          end
          len_d = len_after;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          s1_v_d   = 1'b1;
          s1_idx_d = cnt_q[SLOT_W-1:0];
          cnt_d    = cnt_q + LEN_W'(1);
        end
        if (s1_v_q) begin
          s2_v_d    = 1'b1;
          s2_idx_d  = s1_idx_q;
          s2_slot_d = q_rdata_i;
        end
        // strict compare keeps the earliest queued on ties
        if (s2_v_q && (!best_v_q || scan_key < best_key_q)) begin
          best_v_d    = 1'b1;
          best_idx_d  = s2_idx_q;
          best_slot_d = s2_slot_q;
          best_key_d  = scan_key;
        end
      end
      ST_DECIDE: begin
        if (take) begin
          len_d      = len_q - LEN_W'(1);
          sh_rd_d    = LEN_W'(best_idx_q) + LEN_W'(1);
          running_d  = 1'b1;
          rslot_d    = best_slot_q;
          ql_d       = quantum_i;
          disp_d     = 1'b1;
          app_d      = preempt;
          app_slot_d = rslot_q;
        end
      end
      ST_SHIFT: begin
        if (sh_issue) begin
          sh_wv_d = 1'b1;
          sh_wa_d = sh_rd_q[SLOT_W-1:0] - SLOT_W'(1);
          sh_rd_d = sh_rd_q + LEN_W'(1);
        end
      end
      ST_APPEND: len_d = len_q + LEN_W'(1);
      ST_DONE:   if (res_ready_i) time_d = time_q + TIME_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    res_o.time_res    = time_q;
    res_o.idle        = !running_q;
    res_o.running_id  = running_q ? rslot_q : '0;
    res_o.dispatched  = disp_q;
    res_o.finished    = fin_q;
    res_o.finished_id = fin_id_q;
    res_o.turnaround  = tat_q;
    res_o.waiting     = wt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      unfin_q   <= '0;
      running_q <= 1'b0;
      rslot_q   <= '0;
      ql_q      <= QUANT_RESET;
      time_q    <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      sh_wv_q   <= 1'b0;
      best_v_q  <= 1'b0;
      app_q     <= 1'b0;
      fin_q     <= 1'b0;
      disp_q    <= 1'b0;
      cnt_q     <= '0;
      sh_rd_q   <= '0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      unfin_q   <= unfin_d;
      running_q <= running_d;
      rslot_q   <= rslot_d;
      ql_q      <= ql_d;
      time_q    <= time_d;
      s1_v_q    <= s1_v_d;
      s2_v_q    <= s2_v_d;
      sh_wv_q   <= sh_wv_d;
      best_v_q  <= best_v_d;
      app_q     <= app_d;
      fin_q     <= fin_d;
      disp_q    <= disp_d;
      cnt_q     <= cnt_d;
      sh_rd_q   <= sh_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_key_q   <= run_key_d;
    fin_id_q    <= fin_id_d;
    tat_q       <= tat_d;
    wt_q        <= wt_d;
    s1_idx_q    <= s1_idx_d;
    s2_idx_q    <= s2_idx_d;
    s2_slot_q   <= s2_slot_d;
    best_idx_q  <= best_idx_d;
    best_slot_q <= best_slot_d;
    best_key_q  <= best_key_d;
    sh_wa_q     <= sh_wa_d;
    app_slot_q  <= app_slot_d;
  end

  // every unfinished slot is either queued once or running
  `CSCH_ASSERT_IMP(a_slot_count, state_q == ST_IDLE,
    $countones(unfin_q) == (32'(len_q) + 32'(running_q)))
  `CSCH_ASSERT_IMP(a_run_unfin, state_q == ST_IDLE && running_q, unfin_q[rslot_q])
  `CSCH_ASSERT_NXT(a_time_step, state_q == ST_DONE && res_ready_i,
    time_q == $past(time_q) + TIME_W'(1))

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of cpu_process_scheduler: directed table then random
// arrivals/ticks under several mode/quantum settings, checked by an in-bench predictor.
// Depends on csch_pkg and the RTL of cpu_process_scheduler.
`timescale 1ns / 1ps
module tb_top;
  import csch_pkg::*;

  typedef struct packed {
    logic [31:0] waiting;
    logic [31:0] turnaround;
    logic [3:0]  finished_id;
    logic        finished;
    logic        dispatched;
    logic [3:0]  running_id;
    logic        idle;
    logic [31:0] time_res;
  } sched_res_t;

  typedef struct {
    logic        kind;
    logic [3:0]  pid;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic        has_exp;   // typed-in expectation present
    sched_res_t  exp_res;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [QUANT_W-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [31:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [111:0] m_axis_tdata;

  cpu_process_scheduler i_dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // ---------------- predictor state (own copy of the scheduler) ----------------
  logic [3:0]  rq_slot [NPROC];
  int          rq_len;
  logic [31:0] arr_t [NPROC];
  logic [15:0] burst_t [NPROC];
  logic [15:0] rem_t [NPROC];
  logic [7:0]  prio_t [NPROC];
  logic        busy_slot [NPROC];
  logic        cpu_busy;
  logic [3:0]  cur_slot;
  logic [15:0] slice_left;
  logic [31:0] now_t;
  logic [2:0]  mode_r;
  logic [15:0] quantum_r;

  sched_res_t sched_q [$];   // expected schedule results, oldest first
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;

  function automatic mode_e cur_mode();
    return (mode_r > 3'd5) ? MODE_FCFS : mode_e'(mode_r);
  endfunction

  function automatic int slot_key(logic [3:0] s);
    case (cur_mode())
      MODE_SJF, MODE_SRTF:   return rem_t[s];
      MODE_PRIO, MODE_PPRIO: return prio_t[s];
      default:               return 0;
    endcase
  endfunction

  function automatic int best_idx();
    int b;
    b = 0;
    for (int i = 1; i < rq_len; i++)
      if (slot_key(rq_slot[i]) < slot_key(rq_slot[b])) b = i;
    return b;
  endfunction

  function automatic logic [3:0] pull_at(int idx);
    logic [3:0] s;
    s = rq_slot[idx];
    for (int i = idx; i < rq_len - 1; i++) rq_slot[i] = rq_slot[i+1];
    rq_len--;
    return s;
  endfunction

  function automatic void push_tail(logic [3:0] s);
    if (rq_len < NPROC) begin
      rq_slot[rq_len] = s;
      rq_len++;
    end
  endfunction

  function automatic void sched_reset();
    rq_len = 0; cpu_busy = 0; cur_slot = 0; now_t = 0;
    mode_r = 0; quantum_r = 1; slice_left = 1;
    for (int i = 0; i < NPROC; i++) begin
      busy_slot[i] = 0; rem_t[i] = 0; prio_t[i] = 0; burst_t[i] = 0; arr_t[i] = 0;
      rq_slot[i] = 0;
    end
  endfunction

  // One accepted transaction; a tick returns its schedule result.
  function automatic bit sched_step(logic kind, logic [3:0] pid, logic [15:0] bu,
                                    logic [7:0] pr, output sched_res_t r);
    mode_e m;
    int idx;
    logic [3:0] nxt;
    m = cur_mode();
    r = '0;
    if (kind == KIND_ARRIVAL) begin
      if (!busy_slot[pid]) begin
        arr_t[pid] = now_t; burst_t[pid] = bu; rem_t[pid] = bu; prio_t[pid] = pr;
        busy_slot[pid] = 1; push_tail(pid);
      end
      return 0;
    end
    if (cpu_busy) begin
      if (rem_t[cur_slot] <= 1) begin
        rem_t[cur_slot] = 0; busy_slot[cur_slot] = 0; cpu_busy = 0;
        r.finished = 1; r.finished_id = cur_slot;
        r.turnaround = now_t - arr_t[cur_slot];
        r.waiting = r.turnaround - 32'(burst_t[cur_slot]);
      end else rem_t[cur_slot]--;
      if (m == MODE_RR) begin
        slice_left--;
        if (cpu_busy && slice_left == 0) begin
          push_tail(cur_slot); cpu_busy = 0;
        end
      end
    end
    if (cpu_busy && (m == MODE_SRTF || m == MODE_PPRIO) && rq_len > 0) begin
      idx = best_idx();
      if (slot_key(rq_slot[idx]) < slot_key(cur_slot)) begin
        nxt = pull_at(idx); push_tail(cur_slot); cur_slot = nxt;
        slice_left = quantum_r; r.dispatched = 1;
      end
    end
    if (!cpu_busy && rq_len > 0) begin
      cur_slot = pull_at(best_idx()); cpu_busy = 1;
      slice_left = quantum_r; r.dispatched = 1;
    end
    r.time_res = now_t;
    r.idle = !cpu_busy;
    r.running_id = cpu_busy ? cur_slot : 4'd0;
    now_t++;
    return 1;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODE) mode_r = val[2:0]; else quantum_r = val;
  endtask

  // offer one transaction, held until accepted; expectation queued on acceptance.
  // Returns right after the accepting edge; the next falling edge either carries
  // the next transaction or drops tvalid.
  task automatic send_item(logic kind, logic [3:0] pid, logic [15:0] bu, logic [7:0] pr,
                           bit has_exp = 0, sched_res_t fixed = '0);
    sched_res_t r;
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tuser <= kind;
    s_axis_tdata <= {4'd0, pr, bu, pid};
    do @(posedge clk_i); while (!s_axis_tready);
    if (sched_step(kind, pid, bu, pr, r)) begin
      if (has_exp && r !== fixed) begin
        $error("directed row: predictor %h, table %h", r, fixed);
        errors++;
      end
      sched_q.push_back(has_exp ? fixed : r);
    end
  endtask

  task automatic drain();
    int n;
    n = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sched_q.size() > 0 && n < 200000) begin
      @(negedge clk_i); n++;
    end
    repeat (60) @(negedge clk_i);   // margin after the last expected result is in
  endtask

  // ---------------- checker ----------------
  bit hold_off = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off &&
                          !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[106:0];
      if (sched_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
      end else begin
        want = sched_q.pop_front();
        if (got.time_res !== want.time_res) begin
          $error("time_res exp %0d got %0d", want.time_res, got.time_res); errors++; end
        if (got.idle !== want.idle) begin
          $error("idle exp %0d got %0d", want.idle, got.idle); errors++; end
        if (got.running_id !== want.running_id) begin
          $error("running_id exp %0d got %0d", want.running_id, got.running_id); errors++; end
        if (got.dispatched !== want.dispatched) begin
          $error("dispatched exp %0d got %0d", want.dispatched, got.dispatched); errors++; end
        if (got.finished !== want.finished) begin
          $error("finished exp %0d got %0d", want.finished, got.finished); errors++; end
        if (got.finished_id !== want.finished_id) begin
          $error("finished_id exp %0d got %0d", want.finished_id, got.finished_id); errors++; end
        if (got.turnaround !== want.turnaround) begin
          $error("turnaround exp %0d got %0d", want.turnaround, got.turnaround); errors++; end
        if (got.waiting !== want.waiting) begin
          $error("waiting exp %0d got %0d", want.waiting, got.waiting); errors++; end
      end
    end
  end

  // random workload: arrivals (35 percent) mixed in with ticks, which carry junk payload fields
  task automatic random_phase(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 35)
        send_item(KIND_ARRIVAL, 4'($urandom_range(15)),
                  ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8)),
                  8'($urandom), 0);
      else
        send_item(KIND_TICK, 4'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  // ---------------- directed table ----------------
  function automatic sched_res_t mk(logic [31:0] t, logic idl, logic [3:0] rid, logic d);
    sched_res_t r;
    r = '0; r.time_res = t; r.idle = idl; r.running_id = rid; r.dispatched = d;
    return r;
  endfunction

  stim_row_t dir_tab [$];

  initial begin
    s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = 0;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    rst_ni = 0;
    sched_reset();
    // tick on empty after reset, arrivals at the field extremes and a duplicate, then mixed ticks/arrivals
    dir_tab = '{
      '{KIND_TICK,    4'd0,  16'd0,     8'd0,   1, mk(0, 1, 0, 0)},
      '{KIND_ARRIVAL, 4'd15, 16'hFFFF,  8'hFF,  0, '0},
      '{KIND_ARRIVAL, 4'd0,  16'd0,     8'd0,   0, '0},   // zero burst
      '{KIND_ARRIVAL, 4'd15, 16'd3,     8'd1,   0, '0},   // duplicate: ignored
      '{KIND_TICK,    4'hF,  16'hFFFF,  8'hFF,  1, mk(1, 0, 15, 1)},
      '{KIND_TICK,    4'd0,  16'd0,     8'd0,   0, '0},
      '{KIND_ARRIVAL, 4'd5,  16'd2,     8'd9,   0, '0},
      '{KIND_ARRIVAL, 4'd6,  16'd1,     8'd2,   0, '0},
      '{KIND_TICK,    4'd0,  16'd0,     8'd0,   0, '0},
      '{KIND_TICK,    4'd0,  16'd0,     8'd0,   0, '0}
    };
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    foreach (dir_tab[i])
      send_item(dir_tab[i].kind, dir_tab[i].pid, dir_tab[i].burst, dir_tab[i].prio,
                dir_tab[i].has_exp, dir_tab[i].exp_res);
    drain();

    // walk every mode; round robin with quantum 1, quantum 0 and FFFF under other modes, codes 6/7 as fcfs
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 75; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 75; end
        default: begin send_idle_pct = 22; recv_idle_pct = 22; end
      endcase
      write_reg(CFG_MODE, 16'(ph < 8 ? ph % 6 : ph - 2));
      write_reg(CFG_QUANTUM, ph == 5 ? 16'd1 : ph == 9 ? 16'hFFFF : ph == 7 ? 16'd0
                                     : 16'($urandom_range(1, 4)));
      if (ph == 3) begin
        // long receiver hold-off while ticks keep coming
        hold_off = 1;
        fork
          begin repeat (400) @(negedge clk_i); hold_off = 0; end
          random_phase(20);
        join
      end
      random_phase(48);
      drain();   // sender pauses until all results are in
    end
    send_idle_pct = 0; recv_idle_pct = 0;
    drain();
    if (errors == 0 && sched_q.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/csch_pkg.sv
hw/rtl/csch_ram.sv
hw/rtl/csch_ctrl.sv
hw/rtl/cpu_process_scheduler.sv
test/tb_top.sv
